>>> rtl/sbe_pkg.sv
// Shared widths, codes and control/status types for the band energy block.
package sbe_pkg;

    // Field and register widths
    localparam int MAG_W  = 32;
    localparam int EDGE_W = 17;
    localparam int SR_W   = 18;
    localparam int NORM_W = 32;
    localparam int DB_W   = 17;
    localparam int ST_W   = 2;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 32;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_LOW_EDGE  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_HIGH_EDGE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SAMPLE_RT = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_NORM      = 2'd3;

    // Register reset values
    localparam logic [EDGE_W-1:0] RST_LOW_EDGE  = 17'd0;
    localparam logic [EDGE_W-1:0] RST_HIGH_EDGE = 17'd8000;
    localparam logic [SR_W-1:0]   RST_SAMPLE_RT = 18'd16000;
    localparam logic [NORM_W-1:0] RST_NORM      = 32'd16777216;

    // Status codes
    localparam logic [ST_W-1:0] ST_VALID = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FLOOR = 2'd2;

    // Frame state
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
    localparam int SUM_W = 42;

    // Floor test: den < 2^42, so a sum of 2^13 or more is never below 1e-9 of it
    localparam int FLOOR_SUM_W = 13;
    localparam int E9_W        = 30;
    localparam int FP_W        = FLOOR_SUM_W + E9_W;
    localparam logic [E9_W-1:0] ONE_E9 = 30'd1000000000;

    // log2 unit, Q.30 output
    localparam int LOG_EW = 6;
    localparam int LOG_FW = 30;
    localparam int LOG_W  = LOG_EW + LOG_FW;
    localparam int LOG_MW = 32;

    // dB scaling: 20*log10(2) in Q.20, product split in two partial products
    localparam int K_W     = 23;
    localparam logic [K_W-1:0] K20LOG2 = 23'd6313057;
    localparam int D_SPLIT = 18;
    localparam int PP_W    = D_SPLIT + K_W;
    localparam int RND_W   = 60;
    localparam int RND_SH  = 42;
    localparam int Q_W     = RND_W - RND_SH;
    localparam logic [RND_W-1:0] RND_HALF = 60'h200_0000_0000;
    localparam logic [Q_W-1:0]  Q_FLOOR  = 18'd46080;
    localparam logic [Q_W-1:0]  Q_CEIL   = 18'd49408;
    localparam logic [DB_W-1:0] DB_FLOOR = 17'h14C00;
    localparam logic [DB_W-1:0] DB_CEIL  = 17'd49408;

    typedef struct packed {
        logic acc_in;     // add the bin on the input port
        logic hold_in;    // capture the input request
        logic lim_start;  // start the band limit dividers
        logic acc_held;   // add the captured bin
        logic den_calc;   // form denominator and floor product
        logic log_start;
        logic log_sel;    // 0: band sum, 1: denominator
        logic diff_calc;
        logic mul_lo;
        logic mul_hi;
        logic set_empty;
        logic set_floor;
        logic set_level;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic held_last;
        logic div_done;
        logic log_done;
        logic empty;
        logic floor_hit;
    } t_sts;

endpackage

>>> rtl/sbe_div.sv
// Restoring divider, one quotient bit per cycle.
module sbe_div #(
    parameter int NUM_W = 27,
    parameter int DIV_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_div,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;

    logic [DIV_W:0] w_tmp;
    logic [DIV_W:0] w_sub;
    logic           w_ge;

    assign w_tmp = {r_rem, r_quo[NUM_W-1]};
    assign w_ge  = w_tmp >= {1'b0, i_div};
    assign w_sub = w_tmp - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_tmp[DIV_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/sbe_log2.sv
// Iterative log2 in Q.30: msb search by shifting, then one squaring per fraction bit.
module sbe_log2 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sbe_pkg::SUM_W-1:0] i_x,
    output logic                      o_done,
    output logic [sbe_pkg::LOG_W-1:0] o_log
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;
    localparam int IW = 5;
    localparam logic [IW-1:0] LAST_I = IW'(sbe_pkg::LOG_FW - 1);

    logic [1:0]                       r_state;
    logic                             r_done;
    logic [sbe_pkg::SUM_W-1:0]        r_x;
    logic [sbe_pkg::LOG_EW-1:0]       r_e;
    logic [sbe_pkg::LOG_MW-1:0]       r_m;
    logic [sbe_pkg::LOG_FW-1:0]       r_frac;
    logic [IW-1:0]                    r_i;

    logic [2*sbe_pkg::LOG_MW-1:0]     w_sq;
    logic [sbe_pkg::LOG_MW:0]         w_t;

    assign w_sq = r_m * r_m;
    assign w_t  = w_sq[2*sbe_pkg::LOG_MW-1:sbe_pkg::LOG_MW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (r_x[sbe_pkg::SUM_W-1] || (r_e == '0)) begin
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    if (r_i == LAST_I) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_x <= i_x;
                    r_e <= sbe_pkg::LOG_EW'(sbe_pkg::SUM_W - 1);
                end
            end
            L_NORM: begin
                if (r_x[sbe_pkg::SUM_W-1] || (r_e == '0)) begin
                    r_m    <= r_x[sbe_pkg::SUM_W-1 -: sbe_pkg::LOG_MW];
                    r_i    <= '0;
                    r_frac <= '0;
                end else begin
                    r_x <= {r_x[sbe_pkg::SUM_W-2:0], 1'b0};
                    r_e <= r_e - 1'b1;
                end
            end
            L_SQ: begin
                r_m    <= w_t[sbe_pkg::LOG_MW] ? w_t[sbe_pkg::LOG_MW:1]
                                               : w_t[sbe_pkg::LOG_MW-1:0];
                r_frac <= {r_frac[sbe_pkg::LOG_FW-2:0], w_t[sbe_pkg::LOG_MW]};
                r_i    <= r_i + 1'b1;
            end
            default: begin
                r_i <= '0;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_log  = {r_e, r_frac};

endmodule

>>> rtl/sbe_dp.sv
// Datapath: registers, band limits, bin accumulation, dB arithmetic and result registers.
module sbe_dp #(
    parameter int FFT_POINTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sbe_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [sbe_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic [sbe_pkg::MAG_W-1:0]   i_mag,
    input  logic                        i_last,
    input  sbe_pkg::t_cmd               i_cmd,
    output sbe_pkg::t_sts               o_sts,
    output logic [sbe_pkg::DB_W-1:0]    o_db,
    output logic [sbe_pkg::ST_W-1:0]    o_status
);

    localparam int HALF  = FFT_POINTS / 2;
    localparam int BIN_W = $clog2(HALF + 1);
    localparam int NUM_W = sbe_pkg::EDGE_W + $clog2(FFT_POINTS);
    localparam int DEN_W = BIN_W + sbe_pkg::NORM_W;
    localparam logic [NUM_W-1:0] PTS_Q  = NUM_W'(FFT_POINTS);
    localparam logic [NUM_W-1:0] HALF_Q = NUM_W'(HALF);
    localparam logic [NUM_W-1:0] ONE_Q  = NUM_W'(1);

    // configuration
    logic [sbe_pkg::EDGE_W-1:0] r_low;
    logic [sbe_pkg::EDGE_W-1:0] r_high;
    logic [sbe_pkg::SR_W-1:0]   r_sr;
    logic [sbe_pkg::NORM_W-1:0] r_norm;

    // frame state
    logic [sbe_pkg::CNT_W-1:0]  r_cnt;
    logic [sbe_pkg::SUM_W-1:0]  r_sum;
    logic [BIN_W-1:0]           r_first;
    logic [BIN_W-1:0]           r_end;

    // payload
    logic [sbe_pkg::MAG_W-1:0]  r_mag;
    logic                       r_last;
    logic [DEN_W-1:0]           r_den;
    logic [sbe_pkg::FP_W-1:0]   r_fprod;
    logic [sbe_pkg::LOG_W-1:0]  r_ln;
    logic [sbe_pkg::LOG_W-1:0]  r_ld;
    logic [sbe_pkg::LOG_W-1:0]  r_d;
    logic                       r_neg;
    logic [sbe_pkg::RND_W-1:0]  r_prod;
    logic [sbe_pkg::DB_W-1:0]   r_res_db;
    logic [sbe_pkg::ST_W-1:0]   r_res_st;
    logic [sbe_pkg::DB_W-1:0]   r_out_db;
    logic [sbe_pkg::ST_W-1:0]   r_out_st;

    logic [sbe_pkg::SR_W-1:0]   w_sr;
    logic [NUM_W-1:0]           w_num_lo;
    logic [NUM_W-1:0]           w_num_hi;
    logic [NUM_W-1:0]           w_q_lo;
    logic [NUM_W-1:0]           w_q_hi;
    logic                       w_div_done;
    logic                       w_acc;
    logic [sbe_pkg::MAG_W-1:0]  w_acc_mag;
    logic                       w_in_band;
    logic [BIN_W-1:0]           w_diff;
    logic [sbe_pkg::NORM_W-1:0] w_norm;
    logic [DEN_W-1:0]           w_den;
    logic [sbe_pkg::FP_W-1:0]   w_fprod;
    logic [sbe_pkg::SUM_W-1:0]  w_log_x;
    logic                       w_log_done;
    logic [sbe_pkg::LOG_W-1:0]  w_log;
    logic [sbe_pkg::PP_W-1:0]   w_plo;
    logic [sbe_pkg::PP_W-1:0]   w_phi;
    logic [sbe_pkg::RND_W-1:0]  w_rsum;
    logic [sbe_pkg::Q_W-1:0]    w_q;
    logic [sbe_pkg::Q_W-1:0]    w_q_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= sbe_pkg::RST_LOW_EDGE;
            r_high <= sbe_pkg::RST_HIGH_EDGE;
            r_sr   <= sbe_pkg::RST_SAMPLE_RT;
            r_norm <= sbe_pkg::RST_NORM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sbe_pkg::CFG_LOW_EDGE:  r_low  <= i_cfg_data[sbe_pkg::EDGE_W-1:0];
                sbe_pkg::CFG_HIGH_EDGE: r_high <= i_cfg_data[sbe_pkg::EDGE_W-1:0];
                sbe_pkg::CFG_SAMPLE_RT: r_sr   <= i_cfg_data[sbe_pkg::SR_W-1:0];
                sbe_pkg::CFG_NORM:      r_norm <= i_cfg_data[sbe_pkg::NORM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // band limits: edge * points / rate
    assign w_sr     = (r_sr == '0) ? sbe_pkg::SR_W'(1) : r_sr;
    assign w_num_lo = NUM_W'(r_low) * PTS_Q;
    assign w_num_hi = NUM_W'(r_high) * PTS_Q;

    sbe_div #(.NUM_W(NUM_W), .DIV_W(sbe_pkg::SR_W)) u_div_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lim_start),
        .i_num   (w_num_lo),
        .i_div   (w_sr),
        .o_done  (w_div_done),
        .o_quo   (w_q_lo)
    );

    sbe_div #(.NUM_W(NUM_W), .DIV_W(sbe_pkg::SR_W)) u_div_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lim_start),
        .i_num   (w_num_hi),
        .i_div   (w_sr),
        .o_done  (),
        .o_quo   (w_q_hi)
    );

    assign w_acc     = i_cmd.acc_in | i_cmd.acc_held;
    assign w_acc_mag = i_cmd.acc_held ? r_mag : i_mag;
    assign w_in_band = (r_cnt >= sbe_pkg::CNT_W'(r_first)) &&
                       (r_cnt <  sbe_pkg::CNT_W'(r_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_first <= '0;
            r_end   <= '0;
        end else begin
            if (w_div_done) begin
                r_first <= (w_q_lo < ONE_Q)  ? BIN_W'(1) :
                           (w_q_lo > HALF_Q) ? BIN_W'(HALF) : w_q_lo[BIN_W-1:0];
                r_end   <= (w_q_hi > HALF_Q) ? BIN_W'(HALF) : w_q_hi[BIN_W-1:0];
            end
            if (i_cmd.load_out) begin
                r_cnt <= '0;
                r_sum <= '0;
            end else if (w_acc) begin
                if (w_in_band) begin
                    r_sum <= r_sum + sbe_pkg::SUM_W'(w_acc_mag);
                end
                if (r_cnt != sbe_pkg::CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // denominator and floor product
    assign w_diff  = r_end - r_first;
    assign w_norm  = (r_norm == '0) ? sbe_pkg::NORM_W'(1) : r_norm;
    assign w_den   = w_diff * w_norm;
    assign w_fprod = r_sum[sbe_pkg::FLOOR_SUM_W-1:0] * sbe_pkg::ONE_E9;

    assign w_log_x = i_cmd.log_sel ? sbe_pkg::SUM_W'(r_den) : r_sum;

    sbe_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_x     (w_log_x),
        .o_done  (w_log_done),
        .o_log   (w_log)
    );

    assign w_plo   = r_d[sbe_pkg::D_SPLIT-1:0] * sbe_pkg::K20LOG2;
    assign w_phi   = r_d[sbe_pkg::LOG_W-1:sbe_pkg::D_SPLIT] * sbe_pkg::K20LOG2;
    assign w_rsum  = r_prod + sbe_pkg::RND_HALF;
    assign w_q     = w_rsum[sbe_pkg::RND_W-1:sbe_pkg::RND_SH];
    assign w_q_neg = ~w_q + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_in) begin
            r_mag  <= i_mag;
            r_last <= i_last;
        end
        if (i_cmd.den_calc) begin
            r_den   <= w_den;
            r_fprod <= w_fprod;
        end
        if (w_log_done) begin
            if (i_cmd.log_sel) begin
                r_ld <= w_log;
            end else begin
                r_ln <= w_log;
            end
        end
        if (i_cmd.diff_calc) begin
            r_neg <= r_ld > r_ln;
            r_d   <= (r_ld > r_ln) ? (r_ld - r_ln) : (r_ln - r_ld);
        end
        if (i_cmd.mul_lo) begin
            r_prod <= sbe_pkg::RND_W'(w_plo);
        end
        if (i_cmd.mul_hi) begin
            r_prod <= r_prod + sbe_pkg::RND_W'({w_phi, {sbe_pkg::D_SPLIT{1'b0}}});
        end
        if (i_cmd.set_empty) begin
            r_res_db <= '0;
            r_res_st <= sbe_pkg::ST_EMPTY;
        end
        if (i_cmd.set_floor) begin
            r_res_db <= sbe_pkg::DB_FLOOR;
            r_res_st <= sbe_pkg::ST_FLOOR;
        end
        if (i_cmd.set_level) begin
            if (r_neg) begin
                r_res_db <= (w_q > sbe_pkg::Q_FLOOR) ? sbe_pkg::DB_FLOOR
                                                     : w_q_neg[sbe_pkg::DB_W-1:0];
            end else begin
                r_res_db <= (w_q > sbe_pkg::Q_CEIL) ? sbe_pkg::DB_CEIL
                                                    : w_q[sbe_pkg::DB_W-1:0];
            end
            r_res_st <= sbe_pkg::ST_VALID;
        end
        if (i_cmd.load_out) begin
            r_out_db <= r_res_db;
            r_out_st <= r_res_st;
        end
    end

    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.held_last = r_last;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.log_done  = w_log_done;
    assign o_sts.empty     = (r_end <= r_first);
    assign o_sts.floor_hit = (r_sum[sbe_pkg::SUM_W-1:sbe_pkg::FLOOR_SUM_W] == '0) &&
                             (r_fprod <= sbe_pkg::FP_W'(r_den));

    assign o_db     = r_out_db;
    assign o_status = r_out_st;

endmodule

>>> rtl/sbe_ctrl.sv
// Controller: sequences bin intake, limit division, log passes and the result register.
module sbe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  sbe_pkg::t_sts i_sts,
    output sbe_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LIM  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_DEN  = 4'd3;
    localparam logic [3:0] S_CLS  = 4'd4;
    localparam logic [3:0] S_LOGN = 4'd5;
    localparam logic [3:0] S_LSTD = 4'd6;
    localparam logic [3:0] S_LOGD = 4'd7;
    localparam logic [3:0] S_SUB  = 4'd8;
    localparam logic [3:0] S_MLO  = 4'd9;
    localparam logic [3:0] S_MHI  = 4'd10;
    localparam logic [3:0] S_RND  = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.hold_in = 1'b1;
                    if (i_sts.cnt_zero) begin
                        o_cmd.lim_start = 1'b1;
                        n_state = S_LIM;
                    end else begin
                        o_cmd.acc_in = 1'b1;
                        n_state = i_s_tlast ? S_DEN : S_IDLE;
                    end
                end
            end
            S_LIM: begin
                if (i_sts.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_held = 1'b1;
                n_state = i_sts.held_last ? S_DEN : S_IDLE;
            end
            S_DEN: begin
                o_cmd.den_calc = 1'b1;
                n_state = S_CLS;
            end
            S_CLS: begin
                if (i_sts.empty) begin
                    o_cmd.set_empty = 1'b1;
                    n_state = S_EMIT;
                end else if (i_sts.floor_hit) begin
                    o_cmd.set_floor = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.log_start = 1'b1;
                    n_state = S_LOGN;
                end
            end
            S_LOGN: begin
                if (i_sts.log_done) begin
                    n_state = S_LSTD;
                end
            end
            S_LSTD: begin
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel   = 1'b1;
                n_state = S_LOGD;
            end
            S_LOGD: begin
                o_cmd.log_sel = 1'b1;
                if (i_sts.log_done) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.diff_calc = 1'b1;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.set_level = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> i_sts.cnt_zero)
        else $error("frame state not cleared after result load");

    a_div_done_in_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_LIM))
        else $error("limit divider finished outside limit state");

    a_log_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.log_done |-> ((r_state == S_LOGN) || (r_state == S_LOGD)))
        else $error("log unit finished outside a log wait state");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.set_empty, o_cmd.set_floor, o_cmd.set_level, o_cmd.load_out}))
        else $error("conflicting result commands");

endmodule

>>> rtl/spectral_band_energy_dbfs.sv
// Top level: average FFT band level in dB full scale, one result per frame.
//
// Channel     Dir  Handshake                   Payload
// s_axis      in   i_s_axis_tvalid/o_..tready  tdata: magnitude; tlast: frame_end
// m_axis      out  o_m_axis_tvalid/i_..tready  tdata: band_db; tuser: status
// cfg         in   i_cfg_valid/o_cfg_ready     i_cfg_addr: register, i_cfg_data: value
//
// Inside a frame the input stays ready, so bins are taken back to back. The first bin of a
// frame waits for the bit-serial band limit dividers before it is accumulated.
// After the last bin the shared log2 unit (msb search one bit a cycle, then one 32x32
// squaring a cycle) runs on sum and denominator, unless the band is empty or at the floor.
// Reset is synchronous, active low; no clearing pass. A result waits in the output
// register while new bins are taken; only the next frame's result waits for it.
module spectral_band_energy_dbfs #(
    parameter int FFT_POINTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sbe_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,   // [31:0] magnitude
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [sbe_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,   // [16:0] band_db, rest zero
    output logic [sbe_pkg::ST_W-1:0]          o_m_axis_tuser,   // [1:0] status
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbe_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [sbe_pkg::CFG_DW-1:0]        i_cfg_data
);

    sbe_pkg::t_cmd              w_cmd;
    sbe_pkg::t_sts              w_sts;
    logic [sbe_pkg::DB_W-1:0]   w_db;

    assign o_cfg_ready = 1'b1;

    sbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tlast  (i_s_axis_tlast),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sbe_dp #(.FFT_POINTS(FFT_POINTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_mag      (i_s_axis_tdata[sbe_pkg::MAG_W-1:0]),
        .i_last     (i_s_axis_tlast),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_db       (w_db),
        .o_status   (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{(sbe_pkg::OUT_TDATA_W - sbe_pkg::DB_W){1'b0}}, w_db};

endmodule
